/* rtl/core/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, token kinds and sizes for the lox token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int unsigned POS_BITS_DEF  = 24;
	localparam int unsigned LINE_BITS_DEF = 20;
	localparam int unsigned WORD_BUF_LEN  = 6;
	localparam int unsigned WCNT_W        = $clog2(WORD_BUF_LEN + 2);

	localparam int unsigned KIND_W     = 6;
	localparam int unsigned TOK_POS_W  = 24;
	localparam int unsigned TOK_LINE_W = 20;
	localparam int unsigned MAX_TOKENS = 3;
	localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1);

	// token kinds, book order
	localparam logic [KIND_W-1:0] K_LEFT_PAREN    = 6'd0;
	localparam logic [KIND_W-1:0] K_RIGHT_PAREN   = 6'd1;
	localparam logic [KIND_W-1:0] K_LEFT_BRACE    = 6'd2;
	localparam logic [KIND_W-1:0] K_RIGHT_BRACE   = 6'd3;
	localparam logic [KIND_W-1:0] K_COMMA         = 6'd4;
	localparam logic [KIND_W-1:0] K_DOT           = 6'd5;
	localparam logic [KIND_W-1:0] K_MINUS         = 6'd6;
	localparam logic [KIND_W-1:0] K_PLUS          = 6'd7;
	localparam logic [KIND_W-1:0] K_SEMICOLON     = 6'd8;
	localparam logic [KIND_W-1:0] K_SLASH         = 6'd9;
	localparam logic [KIND_W-1:0] K_STAR          = 6'd10;
	localparam logic [KIND_W-1:0] K_BANG          = 6'd11;
	localparam logic [KIND_W-1:0] K_BANG_EQUAL    = 6'd12;
	localparam logic [KIND_W-1:0] K_EQUAL         = 6'd13;
	localparam logic [KIND_W-1:0] K_EQUAL_EQUAL   = 6'd14;
	localparam logic [KIND_W-1:0] K_GREATER       = 6'd15;
	localparam logic [KIND_W-1:0] K_GREATER_EQUAL = 6'd16;
	localparam logic [KIND_W-1:0] K_LESS          = 6'd17;
	localparam logic [KIND_W-1:0] K_LESS_EQUAL    = 6'd18;
	localparam logic [KIND_W-1:0] K_IDENTIFIER    = 6'd19;
	localparam logic [KIND_W-1:0] K_STRING        = 6'd20;
	localparam logic [KIND_W-1:0] K_NUMBER        = 6'd21;
	localparam logic [KIND_W-1:0] K_AND           = 6'd22;
	localparam logic [KIND_W-1:0] K_CLASS         = 6'd23;
	localparam logic [KIND_W-1:0] K_ELSE          = 6'd24;
	localparam logic [KIND_W-1:0] K_FALSE         = 6'd25;
	localparam logic [KIND_W-1:0] K_FUN           = 6'd26;
	localparam logic [KIND_W-1:0] K_FOR           = 6'd27;
	localparam logic [KIND_W-1:0] K_IF            = 6'd28;
	localparam logic [KIND_W-1:0] K_NIL           = 6'd29;
	localparam logic [KIND_W-1:0] K_OR            = 6'd30;
	localparam logic [KIND_W-1:0] K_PRINT         = 6'd31;
	localparam logic [KIND_W-1:0] K_RETURN        = 6'd32;
	localparam logic [KIND_W-1:0] K_SUPER         = 6'd33;
	localparam logic [KIND_W-1:0] K_THIS          = 6'd34;
	localparam logic [KIND_W-1:0] K_TRUE          = 6'd35;
	localparam logic [KIND_W-1:0] K_VAR           = 6'd36;
	localparam logic [KIND_W-1:0] K_WHILE         = 6'd37;
	localparam logic [KIND_W-1:0] K_EOF           = 6'd38;
	localparam logic [KIND_W-1:0] K_BAD_CHAR      = 6'd39;
	localparam logic [KIND_W-1:0] K_UNTERMINATED  = 6'd40;

	typedef enum logic [3:0] {
		M_IDLE,
		M_OP,
		M_SLASH,
		M_COMMENT,
		M_STRING,
		M_INT,
		M_DOT,
		M_FRAC,
		M_IDENT
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_mark;
	} byte_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [TOK_POS_W-1:0]  start;
		logic [TOK_POS_W-1:0]  length;
		logic [TOK_LINE_W-1:0] line;
	} tok_t;

	// tokens caused by one byte, in emission order
	typedef struct packed {
		tok_t [MAX_TOKENS-1:0] slot;
		logic [CNT_W-1:0]      count;
	} tok_set_t;

	typedef struct packed {
		logic [KIND_W-1:0]     token_kind;
		logic [TOK_POS_W-1:0]  token_start;
		logic [TOK_POS_W-1:0]  token_length;
		logic [TOK_LINE_W-1:0] token_line;
		logic                  last_of_run;
	} token_word_t;

endpackage

/* rtl/core/lts_kw_match.sv */
// ----------------------------------------------------------------------------
// lts_kw_match
// Compares the identifier buffer against the sixteen reserved words.
// ----------------------------------------------------------------------------
module lts_kw_match (
	input  logic [lts_pkg::WORD_BUF_LEN-1:0][7:0] wbuf,
	input  logic [lts_pkg::WCNT_W-1:0]            wcnt,
	output logic [lts_pkg::KIND_W-1:0]            kind
);

	localparam int unsigned WBL = lts_pkg::WORD_BUF_LEN;
	localparam int unsigned WCW = lts_pkg::WCNT_W;
	localparam int unsigned NKW = 16;

	// byte 0 of the word sits in the low bits
	function automatic logic [WBL*8-1:0] kw_text(input logic [3:0] i);
		case (i)
			4'd0:    return 48'h000000646e61;
			4'd1:    return 48'h007373616c63;
			4'd2:    return 48'h000065736c65;
			4'd3:    return 48'h0065736c6166;
			4'd4:    return 48'h0000006e7566;
			4'd5:    return 48'h000000726f66;
			4'd6:    return 48'h000000006669;
			4'd7:    return 48'h0000006c696e;
			4'd8:    return 48'h00000000726f;
			4'd9:    return 48'h00746e697270;
			4'd10:   return 48'h6e7275746572;
			4'd11:   return 48'h007265707573;
			4'd12:   return 48'h000073696874;
			4'd13:   return 48'h000065757274;
			4'd14:   return 48'h000000726176;
			4'd15:   return 48'h00656c696877;
			default: return '0;
		endcase
	endfunction

	function automatic logic [WCW-1:0] kw_len(input logic [3:0] i);
		case (i)
			4'd0, 4'd4, 4'd5, 4'd7, 4'd14:         return WCW'(3);
			4'd1, 4'd3, 4'd9, 4'd11, 4'd15:        return WCW'(5);
			4'd2, 4'd12, 4'd13:                    return WCW'(4);
			4'd6, 4'd8:                            return WCW'(2);
			4'd10:                                 return WCW'(6);
			default:                               return '0;
		endcase
	endfunction

	function automatic logic [lts_pkg::KIND_W-1:0] kw_kind(input logic [3:0] i);
		case (i)
			4'd0:    return lts_pkg::K_AND;
			4'd1:    return lts_pkg::K_CLASS;
			4'd2:    return lts_pkg::K_ELSE;
			4'd3:    return lts_pkg::K_FALSE;
			4'd4:    return lts_pkg::K_FUN;
			4'd5:    return lts_pkg::K_FOR;
			4'd6:    return lts_pkg::K_IF;
			4'd7:    return lts_pkg::K_NIL;
			4'd8:    return lts_pkg::K_OR;
			4'd9:    return lts_pkg::K_PRINT;
			4'd10:   return lts_pkg::K_RETURN;
			4'd11:   return lts_pkg::K_SUPER;
			4'd12:   return lts_pkg::K_THIS;
			4'd13:   return lts_pkg::K_TRUE;
			4'd14:   return lts_pkg::K_VAR;
			4'd15:   return lts_pkg::K_WHILE;
			default: return lts_pkg::K_IDENTIFIER;
		endcase
	endfunction

	always_comb begin
		logic             hit;
		logic [WBL*8-1:0] txt;
		logic [WCW-1:0]   len;
		kind = lts_pkg::K_IDENTIFIER;
		for (int i = 0; i < NKW; i++) begin
			txt = kw_text(4'(i));
			len = kw_len(4'(i));
			hit = (len == wcnt);
			// only bytes inside the word length are looked at
			for (int j = 0; j < WBL; j++) begin
				if (WCW'(j) < len && wbuf[j] != txt[j*8 +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				kind = kw_kind(4'(i));
			end
		end
	end

endmodule

/* rtl/core/lts_scan.sv */
// ----------------------------------------------------------------------------
// lts_scan
// Scanner state and the single-pass decode of one byte into up to three tokens.
// ----------------------------------------------------------------------------
module lts_scan #(
	parameter int unsigned POS_BITS  = lts_pkg::POS_BITS_DEF,
	parameter int unsigned LINE_BITS = lts_pkg::LINE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  lts_pkg::byte_word_t  word_s1,
	output lts_pkg::tok_set_t    toks
);

	localparam int unsigned TPW = lts_pkg::TOK_POS_W;
	localparam int unsigned TLW = lts_pkg::TOK_LINE_W;
	localparam int unsigned WBL = lts_pkg::WORD_BUF_LEN;
	localparam int unsigned WCW = lts_pkg::WCNT_W;
	localparam int unsigned WIW = $clog2(WBL);
	localparam int unsigned CW  = lts_pkg::CNT_W;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	lts_pkg::mode_t                 mode_q, mode_d;
	logic [7:0]                     pend_q, pend_d;
	logic [POS_BITS-1:0]            ls_q, ls_d;
	logic [POS_BITS-1:0]            pos_q, pos_d;
	logic [LINE_BITS-1:0]           line_q, line_d;
	logic [WCW-1:0]                 wcnt_q, wcnt_d;
	logic [WBL-1:0][7:0]            wbuf_q;

	logic [POS_BITS-1:0]            p_inc, p_dec;
	logic [LINE_BITS-1:0]           line_inc;
	logic [lts_pkg::KIND_W-1:0]     word_kind;
	logic [7:0]                     c;
	logic                           is_dig, is_alp;
	logic                           consumed, use_flush;
	logic                           fl_va, fl_vb, vc;
	lts_pkg::tok_t                  fl_a, fl_b, tok_c;
	logic                           wr_en;
	logic [WIW-1:0]                 wr_idx;

	function automatic logic [POS_BITS-1:0] sat_sub(input logic [POS_BITS-1:0] a,
			input logic [POS_BITS-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic logic [lts_pkg::KIND_W-1:0] op_kind(input logic [7:0] ch,
			input logic two);
		case (ch)
			"!":     return two ? lts_pkg::K_BANG_EQUAL : lts_pkg::K_BANG;
			"=":     return two ? lts_pkg::K_EQUAL_EQUAL : lts_pkg::K_EQUAL;
			">":     return two ? lts_pkg::K_GREATER_EQUAL : lts_pkg::K_GREATER;
			default: return two ? lts_pkg::K_LESS_EQUAL : lts_pkg::K_LESS;
		endcase
	endfunction

	function automatic lts_pkg::tok_t mk_tok(input logic [lts_pkg::KIND_W-1:0] kind,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len,
			input logic [LINE_BITS-1:0] line);
		lts_pkg::tok_t t;
		t.kind   = kind;
		t.start  = TPW'(start);
		t.length = TPW'(len);
		t.line   = TLW'(line);
		return t;
	endfunction

	lts_kw_match u_kw_match (
		.wbuf (wbuf_q),
		.wcnt (wcnt_q),
		.kind (word_kind)
	);

	assign p_inc    = (pos_q == '1) ? pos_q : pos_q + POS_BITS'(1);
	assign p_dec    = sat_sub(pos_q, POS_BITS'(1));
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

	// token(s) that close whatever is pending
	always_comb begin
		fl_va = 1'b0;
		fl_vb = 1'b0;
		fl_a  = mk_tok(lts_pkg::K_EOF, pos_q, '0, line_q);
		fl_b  = fl_a;
		case (mode_q)
			lts_pkg::M_OP: begin
				fl_va = 1'b1;
				fl_a  = mk_tok(op_kind(pend_q, 1'b0), ls_q, POS_BITS'(1), line_q);
			end
			lts_pkg::M_SLASH: begin
				fl_va = 1'b1;
				fl_a  = mk_tok(lts_pkg::K_SLASH, ls_q, POS_BITS'(1), line_q);
			end
			lts_pkg::M_STRING: begin
				fl_va = 1'b1;
				fl_a  = mk_tok(lts_pkg::K_UNTERMINATED, ls_q, sat_sub(pos_q, ls_q), line_q);
			end
			lts_pkg::M_INT, lts_pkg::M_FRAC: begin
				fl_va = 1'b1;
				fl_a  = mk_tok(lts_pkg::K_NUMBER, ls_q, sat_sub(pos_q, ls_q), line_q);
			end
			lts_pkg::M_DOT: begin
				// trailing dot was not a fraction: number, then the dot on its own
				fl_va = 1'b1;
				fl_vb = 1'b1;
				fl_a  = mk_tok(lts_pkg::K_NUMBER, ls_q, sat_sub(p_dec, ls_q), line_q);
				fl_b  = mk_tok(lts_pkg::K_DOT, p_dec, POS_BITS'(1), line_q);
			end
			lts_pkg::M_IDENT: begin
				fl_va = 1'b1;
				fl_a  = mk_tok(word_kind, ls_q, sat_sub(pos_q, ls_q), line_q);
			end
			default: begin
				fl_va = 1'b0;
			end
		endcase
	end

	always_comb begin
		c        = word_s1.text_byte;
		is_dig   = (c >= "0") && (c <= "9");
		is_alp   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		mode_d   = mode_q;
		pend_d   = pend_q;
		ls_d     = ls_q;
		pos_d    = p_inc;
		line_d   = line_q;
		wcnt_d   = wcnt_q;
		wr_en    = 1'b0;
		wr_idx   = wcnt_q[WIW-1:0];
		consumed = 1'b0;
		vc       = 1'b0;
		tok_c    = mk_tok(lts_pkg::K_EOF, pos_q, '0, line_q);
		if (word_s1.end_mark) begin
			// flush, then eof, then back to the reset state
			vc     = 1'b1;
			mode_d = lts_pkg::M_IDLE;
			pend_d = '0;
			ls_d   = '0;
			pos_d  = '0;
			line_d = LINE_BITS'(1);
			wcnt_d = '0;
		end else begin
			case (mode_q)
				lts_pkg::M_OP: begin
					if (c == "=") begin
						consumed = 1'b1;
						vc       = 1'b1;
						tok_c    = mk_tok(op_kind(pend_q, 1'b1), ls_q,
							sat_sub(p_inc, ls_q), line_q);
						mode_d   = lts_pkg::M_IDLE;
					end
				end
				lts_pkg::M_SLASH: begin
					if (c == "/") begin
						consumed = 1'b1;
						mode_d   = lts_pkg::M_COMMENT;
					end
				end
				lts_pkg::M_COMMENT: begin
					consumed = (c != CH_NL);
				end
				lts_pkg::M_STRING: begin
					consumed = 1'b1;
					if (c == "\"") begin
						vc     = 1'b1;
						tok_c  = mk_tok(lts_pkg::K_STRING, ls_q, sat_sub(p_inc, ls_q), line_q);
						mode_d = lts_pkg::M_IDLE;
					end else if (c == CH_NL) begin
						line_d = line_inc;
					end
				end
				lts_pkg::M_INT: begin
					if (is_dig) begin
						consumed = 1'b1;
					end else if (c == ".") begin
						consumed = 1'b1;
						mode_d   = lts_pkg::M_DOT;
					end
				end
				lts_pkg::M_DOT: begin
					if (is_dig) begin
						consumed = 1'b1;
						mode_d   = lts_pkg::M_FRAC;
					end
				end
				lts_pkg::M_FRAC: begin
					consumed = is_dig;
				end
				lts_pkg::M_IDENT: begin
					if (is_alp || is_dig) begin
						consumed = 1'b1;
						wr_en    = (wcnt_q < WCW'(WBL));
						// count stops one past the buffer length: too long for a keyword
						if (wcnt_q <= WCW'(WBL)) begin
							wcnt_d = wcnt_q + WCW'(1);
						end
					end
				end
				default: begin
					consumed = 1'b0;
				end
			endcase

			if (!consumed) begin
				mode_d = lts_pkg::M_IDLE;
				case (c)
					"(": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_LEFT_PAREN, pos_q, POS_BITS'(1), line_q);
					end
					")": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_RIGHT_PAREN, pos_q, POS_BITS'(1), line_q);
					end
					"{": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_LEFT_BRACE, pos_q, POS_BITS'(1), line_q);
					end
					"}": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_RIGHT_BRACE, pos_q, POS_BITS'(1), line_q);
					end
					",": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_COMMA, pos_q, POS_BITS'(1), line_q);
					end
					".": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_DOT, pos_q, POS_BITS'(1), line_q);
					end
					"-": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_MINUS, pos_q, POS_BITS'(1), line_q);
					end
					"+": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_PLUS, pos_q, POS_BITS'(1), line_q);
					end
					";": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_SEMICOLON, pos_q, POS_BITS'(1), line_q);
					end
					"*": begin
						vc    = 1'b1;
						tok_c = mk_tok(lts_pkg::K_STAR, pos_q, POS_BITS'(1), line_q);
					end
					"!", "=", "<", ">": begin
						mode_d = lts_pkg::M_OP;
						pend_d = c;
						ls_d   = pos_q;
					end
					"/": begin
						mode_d = lts_pkg::M_SLASH;
						ls_d   = pos_q;
					end
					" ", CH_CR, CH_TAB: begin
						mode_d = lts_pkg::M_IDLE;
					end
					CH_NL: begin
						line_d = line_inc;
					end
					"\"": begin
						mode_d = lts_pkg::M_STRING;
						ls_d   = pos_q;
					end
					default: begin
						if (is_dig) begin
							mode_d = lts_pkg::M_INT;
							ls_d   = pos_q;
						end else if (is_alp) begin
							mode_d = lts_pkg::M_IDENT;
							ls_d   = pos_q;
							wr_en  = 1'b1;
							wr_idx = '0;
							wcnt_d = WCW'(1);
						end else begin
							vc    = 1'b1;
							tok_c = mk_tok(lts_pkg::K_BAD_CHAR, pos_q, POS_BITS'(1), line_q);
						end
					end
				endcase
			end
		end
	end

	// pack flushed tokens ahead of the final one, no gaps
	always_comb begin
		use_flush     = word_s1.end_mark || !consumed;
		toks.slot[0]  = (use_flush && fl_va) ? fl_a : tok_c;
		toks.slot[1]  = (use_flush && fl_vb) ? fl_b : tok_c;
		toks.slot[2]  = tok_c;
		toks.count    = CW'(use_flush && fl_va) + CW'(use_flush && fl_vb) + CW'(vc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lts_pkg::M_IDLE;
			pend_q <= '0;
			ls_q   <= '0;
			pos_q  <= '0;
			line_q <= LINE_BITS'(1);
			wcnt_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			ls_q   <= ls_d;
			pos_q  <= pos_d;
			line_q <= line_d;
			wcnt_q <= wcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en && !word_s1.end_mark) begin
			wbuf_q[wr_idx] <= c;
		end
	end

endmodule

/* rtl/core/lts_tok_buf.sv */
// ----------------------------------------------------------------------------
// lts_tok_buf
// Result register: holds the tokens of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module lts_tok_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  lts_pkg::tok_set_t    toks,
	output logic                 can_load,
	output logic                 token_valid,
	input  logic                 token_stall,
	output lts_pkg::token_word_t token_word
);

	localparam int unsigned CW = lts_pkg::CNT_W;
	localparam int unsigned NT = lts_pkg::MAX_TOKENS;
	localparam int unsigned RW = $clog2(NT);

	lts_pkg::tok_t [NT-1:0] slot_q;
	logic [CW-1:0]          count_q;
	logic [RW-1:0]          rd_q;
	logic                   take, last;
	lts_pkg::tok_t          head;

	assign token_valid = (count_q != '0);
	assign last        = (CW'(rd_q) == count_q - CW'(1));
	assign take        = token_valid && !token_stall;
	// free again once the final token of the run leaves this cycle
	assign can_load    = !token_valid || (take && last);
	assign head        = slot_q[rd_q];

	always_comb begin
		token_word.token_kind   = head.kind;
		token_word.token_start  = head.start;
		token_word.token_length = head.length;
		token_word.token_line   = head.line;
		token_word.last_of_run  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
		end else if (load) begin
			count_q <= toks.count;
			rd_q    <= '0;
		end else if (take) begin
			if (last) begin
				count_q <= '0;
				rd_q    <= '0;
			end else begin
				rd_q <= rd_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= toks.slot;
		end
	end

endmodule

/* rtl/core/lox_token_scanner.sv */
// ----------------------------------------------------------------------------
// lox_token_scanner
// Streaming lexical scanner for Lox source text.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while byte_stall is low and emits tokens
// (kind, start, length, line), with last_of_run set on the final token caused
// by each byte. A byte passes through an input register, is decoded in one
// pass against the scanner state and its tokens land in a result register.
// Throughput is one byte per cycle while each byte yields at most one token
// and token_stall is low; a byte that yields n tokens (up to three, e.g. "1."
// followed by a punctuator or the end mark) holds the byte channel until the
// result register has handed them all out, one per cycle unless stalled. After
// an end mark the scanner is back in its reset state and a new text may follow.
// ----------------------------------------------------------------------------
module lox_token_scanner #(
	parameter int unsigned POS_BITS  = lts_pkg::POS_BITS_DEF,
	parameter int unsigned LINE_BITS = lts_pkg::LINE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  lts_pkg::byte_word_t  byte_word,
	output logic                 token_valid,
	input  logic                 token_stall,
	output lts_pkg::token_word_t token_word
);

	lts_pkg::byte_word_t word_s1;
	logic                valid_s1;
	logic                can_load, fire, accept;
	lts_pkg::tok_set_t   toks;

	assign fire       = valid_s1 && can_load;
	assign byte_stall = valid_s1 && !can_load;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= byte_word;
		end
	end

	lts_scan #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.word_s1 (word_s1),
		.toks    (toks)
	);

	lts_tok_buf u_tok_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire),
		.toks        (toks),
		.can_load    (can_load),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_word  (token_word)
	);

endmodule

/* rtl/core/lts_checker.sv */
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks for the lox token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lts_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input lts_pkg::byte_word_t  byte_word,
	input logic                 token_valid,
	input logic                 token_stall,
	input lts_pkg::token_word_t token_word
);

	// a stalled token word holds
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_word))
		else $error("token word changed while stalled");

	// tokens of one run follow each other without a gap
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_stall && !token_word.last_of_run |=> token_valid)
		else $error("gap inside a token run");

	// eof is always the last of its run and empty
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_word.token_kind == lts_pkg::K_EOF
		|-> token_word.last_of_run && token_word.token_length == '0)
		else $error("malformed eof token");

	// the byte side only waits on tokens still to be delivered
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> token_valid)
		else $error("byte stall with no token pending");

	// a stalled byte word holds
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
		else $error("byte word changed while stalled");

endmodule

bind lox_token_scanner lts_checker u_lts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.byte_word   (byte_word),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_word  (token_word)
);
